// ----- hw/rtl/seqalu_pkg.sv -----
// Package for the sequence variable ALU: payload structs, opcode and status
// codes, and the variable file access structs.
// Depends on nothing; every other file in hw/rtl uses it by scoped names.
`timescale 1ns / 1ps

package seqalu_pkg;

    localparam int DATA_W = 16;
    localparam int CNT_W  = 32;
    localparam int TRK_W  = 4;
    localparam int SLOT_W = 6;

    // Arithmetic opcodes.
    localparam logic [7:0] OP_SET   = 8'h80;
    localparam logic [7:0] OP_ADD   = 8'h81;
    localparam logic [7:0] OP_SUB   = 8'h82;
    localparam logic [7:0] OP_MUL   = 8'h83;
    localparam logic [7:0] OP_DIV   = 8'h84;
    localparam logic [7:0] OP_SHIFT = 8'h85;
    localparam logic [7:0] OP_HALVE = 8'h86;
    localparam logic [7:0] OP_AND   = 8'h87;
    localparam logic [7:0] OP_OR    = 8'h88;
    localparam logic [7:0] OP_XOR   = 8'h89;
    localparam logic [7:0] OP_NOT   = 8'h8A;
    localparam logic [7:0] OP_MOD   = 8'h8B;
    // Compare opcodes.
    localparam logic [7:0] OP_EQ    = 8'h90;
    localparam logic [7:0] OP_GE    = 8'h91;
    localparam logic [7:0] OP_GT    = 8'h92;
    localparam logic [7:0] OP_LE    = 8'h93;
    localparam logic [7:0] OP_LT    = 8'h94;
    localparam logic [7:0] OP_NE    = 8'h95;

    localparam logic [7:0] OP_ARITH_FIRST = OP_SET;
    localparam logic [7:0] OP_ARITH_LAST  = OP_MOD;
    localparam logic [7:0] OP_CMP_FIRST   = OP_EQ;
    localparam logic [7:0] OP_CMP_LAST    = OP_NE;

    // Operand modes; the unused code behaves as a literal.
    localparam logic [1:0] MODE_LITERAL = 2'd0;
    localparam logic [1:0] MODE_SLOT    = 2'd1;
    localparam logic [1:0] MODE_RANDOM  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_BAD_DST  = 3'd1;
    localparam logic [2:0] ST_BAD_SRC  = 3'd2;
    localparam logic [2:0] ST_DIV_ZERO = 3'd3;
    localparam logic [2:0] ST_BAD_OP   = 3'd4;

    typedef struct packed {
        logic [7:0]               opcode;
        logic [TRK_W-1:0]         track;
        logic signed [DATA_W-1:0] var_index;
        logic [1:0]               operand_mode;
        logic signed [DATA_W-1:0] operand;
        logic signed [DATA_W-1:0] rnd_low;
        logic signed [DATA_W-1:0] rnd_high;
    } t_in_item;

    typedef struct packed {
        logic [2:0]               status;
        logic                     did_write;
        logic signed [DATA_W-1:0] written_value;
        logic                     compare_flag;
        logic [CNT_W-1:0]         change_count;
    } t_out_item;

    // One access to the variable file per cycle: a read always, a write when we is set.
    typedef struct packed {
        logic              we;
        logic [TRK_W-1:0]  track;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] wdata;
    } t_vf_acc;

    typedef struct packed {
        logic              written;
        logic [DATA_W-1:0] data;
    } t_vf_rd;

endpackage

// ----- hw/rtl/sequence_variable_alu.sv -----
// Sequence variable ALU: one extended variable instruction per start, one result strobe each.
// A bad opcode, slot or track goes from decode straight to the strobe; a slot operand adds a
// source fetch, and div and mod add the divider after execute; a zero divisor skips the divider.
// busy covers the strobe cycle, so a new instruction is accepted only once the strobe is over.
// Synchronous active-low reset clears the written marks, sets the compare flags, zeroes the count.
`timescale 1ns / 1ps

module sequence_variable_alu #(
    parameter int TRACKS      = 16,
    parameter int SHARED_VARS = 32,
    parameter int LOCAL_VARS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  seqalu_pkg::t_in_item  i_item,
    output logic                  busy,
    output logic                  o_valid,
    output seqalu_pkg::t_out_item o_result
);

    localparam int DW         = seqalu_pkg::DATA_W;
    localparam int TW         = seqalu_pkg::TRK_W;
    localparam int SW         = seqalu_pkg::SLOT_W;
    localparam int SLOT_COUNT = SHARED_VARS + LOCAL_VARS;

    // The sequencer walks one instruction through decode, operand fetch,
    // destination fetch, execute (then the divider for div and mod), write-back and the result strobe.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_SRC   = 8'b0000_0100,
        S_DST   = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Control state.
    logic [TRACKS-1:0]              r_flags;
    logic [seqalu_pkg::CNT_W-1:0]   r_count;

    // Captured instruction and working values.
    logic [7:0]                     r_op;
    logic [TW-1:0]                  r_trk;
    logic signed [DW-1:0]           r_dst;
    logic [1:0]                     r_mode;
    logic signed [DW-1:0]           r_operand;
    logic signed [DW-1:0]           r_lo;
    logic signed [DW-1:0]           r_hi;
    logic signed [DW-1:0]           r_opv;
    logic signed [DW-1:0]           r_cur;
    logic                           r_dst_wr;
    logic signed [DW-1:0]           r_res;
    logic                           r_cmp;
    logic [2:0]                     r_status;
    logic                           r_did;

    logic                           w_arith;
    logic                           w_is_cmp;
    logic                           w_divmod;
    logic                           w_trk_ok;
    logic                           w_dst_ok;
    logic                           w_src_ok;
    logic signed [DW:0]             w_sum;
    logic signed [DW:0]             w_sum_adj;
    logic signed [DW-1:0]           w_mid;
    logic [TRACKS-1:0]              w_trk_sel;
    logic                           w_flag_cur;
    logic signed [DW-1:0]           w_alu_res;
    logic                           w_alu_cmp;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [DW-1:0]                  w_quot;
    logic [DW-1:0]                  w_rem;
    seqalu_pkg::t_vf_acc            w_acc;
    seqalu_pkg::t_vf_rd             w_rd;

    // Instruction decode from the captured fields.
    always_comb begin
        w_arith  = r_op inside {[seqalu_pkg::OP_ARITH_FIRST:seqalu_pkg::OP_ARITH_LAST]};
        w_is_cmp = r_op inside {[seqalu_pkg::OP_CMP_FIRST:seqalu_pkg::OP_CMP_LAST]};
        w_divmod = r_op inside {seqalu_pkg::OP_DIV, seqalu_pkg::OP_MOD};
    end

    assign w_trk_ok = ({1'b0, r_trk} < (TW + 1)'(TRACKS));
    assign w_dst_ok = !r_dst[DW-1] && (r_dst[DW-2:0] < (DW - 1)'(SLOT_COUNT));
    assign w_src_ok = !r_operand[DW-1] && (r_operand[DW-2:0] < (DW - 1)'(SLOT_COUNT));

    // Midpoint of the random range, rounded toward zero.
    assign w_sum     = {r_lo[DW-1], r_lo} + {r_hi[DW-1], r_hi};
    assign w_sum_adj = w_sum + (DW + 1)'(w_sum[DW]);
    assign w_mid     = w_sum_adj[DW:1];

    // One-hot select of the current track's compare flag.
    always_comb begin
        for (int i = 0; i < TRACKS; i++) begin
            w_trk_sel[i] = (r_trk == TW'(i));
        end
    end
    assign w_flag_cur = |(r_flags & w_trk_sel);

    // The variable file sees one access a cycle. The source slot is read while
    // decoding, the destination next, and the destination is written back last.
    always_comb begin
        w_acc.track = r_trk;
        w_acc.wdata = r_res;
        w_acc.we    = (r_state == S_WB) && !w_is_cmp;
        if ((r_state == S_CHECK) && (r_mode == seqalu_pkg::MODE_SLOT)) begin
            w_acc.slot = r_operand[SW-1:0];
        end else begin
            w_acc.slot = r_dst[SW-1:0];
        end
    end

    assign w_div_start = (r_state == S_EXEC) && w_divmod && (r_opv != '0);

    seqalu_varfile #(
        .TRACKS      (TRACKS),
        .SHARED_VARS (SHARED_VARS),
        .LOCAL_VARS  (LOCAL_VARS)
    ) u_varfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .o_rd    (w_rd)
    );

    seqalu_alu u_alu (
        .i_op  (r_op),
        .i_cur (r_cur),
        .i_opv (r_opv),
        .o_res (w_alu_res),
        .o_cmp (w_alu_cmp)
    );

    seqalu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_cur),
        .i_divisor  (r_opv),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Sequencer next state. Unknown opcodes and bad slots or tracks end the
    // instruction right after decode; a zero divisor ends it after execute.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((!w_arith && !w_is_cmp) || !w_trk_ok || !w_dst_ok) begin
                    n_state = S_DONE;
                end else if (r_mode == seqalu_pkg::MODE_SLOT) begin
                    n_state = w_src_ok ? S_SRC : S_DONE;
                end else begin
                    n_state = S_DST;
                end
            end
            S_SRC:  n_state = S_DST;
            S_DST:  n_state = S_EXEC;
            S_EXEC: begin
                if (w_divmod) begin
                    n_state = (r_opv == '0) ? S_DONE : S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_WB;
                end
            end
            S_WB:   n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: state, compare flags and the change counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flags <= '1;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_WB) begin
                if (w_is_cmp) begin
                    // Only a flag that really flips counts as a change.
                    if (r_cmp != w_flag_cur) begin
                        r_flags <= r_flags ^ w_trk_sel;
                        r_count <= r_count + 1'b1;
                    end
                end else if ((r_res != r_cur) || !r_dst_wr) begin
                    // A store counts when the value changes or the slot was never written.
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Working registers, loaded as the instruction moves through the sequencer.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_op      <= i_item.opcode;
                    r_trk     <= i_item.track;
                    r_dst     <= i_item.var_index;
                    r_mode    <= i_item.operand_mode;
                    r_operand <= i_item.operand;
                    r_lo      <= i_item.rnd_low;
                    r_hi      <= i_item.rnd_high;
                    r_status  <= seqalu_pkg::ST_DONE;
                    r_did     <= 1'b0;
                end
            end
            S_CHECK: begin
                if (!w_arith && !w_is_cmp) begin
                    r_status <= seqalu_pkg::ST_BAD_OP;
                end else if (!w_trk_ok || !w_dst_ok) begin
                    r_status <= seqalu_pkg::ST_BAD_DST;
                end else if ((r_mode == seqalu_pkg::MODE_SLOT) && !w_src_ok) begin
                    r_status <= seqalu_pkg::ST_BAD_SRC;
                end
                r_opv <= (r_mode == seqalu_pkg::MODE_RANDOM) ? w_mid : r_operand;
            end
            S_SRC: begin
                r_opv <= w_rd.data;
            end
            S_DST: begin
                r_cur    <= w_rd.data;
                r_dst_wr <= w_rd.written;
            end
            S_EXEC: begin
                r_res <= w_alu_res;
                r_cmp <= w_alu_cmp;
                if (w_divmod && (r_opv == '0)) begin
                    r_status <= seqalu_pkg::ST_DIV_ZERO;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_res <= (r_op == seqalu_pkg::OP_MOD) ? w_rem : w_quot;
                end
            end
            S_WB: begin
                r_did <= !w_is_cmp;
            end
            default: begin
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // Result fields come straight from the working and control registers during the strobe.
    always_comb begin
        o_result.status        = r_status;
        o_result.did_write     = r_did;
        o_result.written_value = r_did ? r_res : '0;
        o_result.compare_flag  = w_trk_ok && w_flag_cur;
        o_result.change_count  = r_count;
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_write_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status != seqalu_pkg::ST_DONE)) |-> !o_result.did_write)
        else $error("variable written by an instruction that failed");

    a_count_only_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WB) |=> $stable(r_count))
        else $error("change counter moved outside write-back");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted instruction did not raise busy");

endmodule

// ----- hw/rtl/seqalu_alu.sv -----
// Combinational arithmetic and compare unit of the sequence variable ALU.
// Depends on seqalu_pkg for opcodes and widths.
`timescale 1ns / 1ps

module seqalu_alu (
    input  logic [7:0]                           i_op,
    input  logic signed [seqalu_pkg::DATA_W-1:0] i_cur,
    input  logic signed [seqalu_pkg::DATA_W-1:0] i_opv,
    output logic signed [seqalu_pkg::DATA_W-1:0] o_res,
    output logic                                 o_cmp
);

    logic signed [2*seqalu_pkg::DATA_W-1:0] w_prod;
    logic [seqalu_pkg::DATA_W-1:0]          w_neg;
    logic [3:0]                             w_rshift;
    logic signed [seqalu_pkg::DATA_W-1:0]   w_hadj;

    assign w_prod   = i_cur * i_opv;
    assign w_neg    = seqalu_pkg::DATA_W'(-i_opv);
    // Right shifts saturate at fifteen places.
    assign w_rshift = (i_opv < -16'sd15) ? 4'd15 : w_neg[3:0];
    // Add one to a negative value so the shift rounds toward zero.
    assign w_hadj   = i_opv + seqalu_pkg::DATA_W'(i_opv[seqalu_pkg::DATA_W-1]);

    always_comb begin
        o_res = '0;
        o_cmp = 1'b0;
        case (i_op)
            seqalu_pkg::OP_SET:   o_res = i_opv;
            seqalu_pkg::OP_ADD:   o_res = i_cur + i_opv;
            seqalu_pkg::OP_SUB:   o_res = i_cur - i_opv;
            seqalu_pkg::OP_MUL:   o_res = w_prod[seqalu_pkg::DATA_W-1:0];
            seqalu_pkg::OP_SHIFT: begin
                if (!i_opv[seqalu_pkg::DATA_W-1]) begin
                    o_res = (i_opv > 16'sd15) ? '0 : (i_cur << i_opv[3:0]);
                end else begin
                    o_res = i_cur >>> w_rshift;
                end
            end
            seqalu_pkg::OP_HALVE: o_res = w_hadj >>> 1;
            seqalu_pkg::OP_AND:   o_res = i_cur & i_opv;
            seqalu_pkg::OP_OR:    o_res = i_cur | i_opv;
            seqalu_pkg::OP_XOR:   o_res = i_cur ^ i_opv;
            seqalu_pkg::OP_NOT:   o_res = ~i_opv;
            seqalu_pkg::OP_EQ:    o_cmp = (i_cur == i_opv);
            seqalu_pkg::OP_GE:    o_cmp = (i_cur >= i_opv);
            seqalu_pkg::OP_GT:    o_cmp = (i_cur > i_opv);
            seqalu_pkg::OP_LE:    o_cmp = (i_cur <= i_opv);
            seqalu_pkg::OP_LT:    o_cmp = (i_cur < i_opv);
            seqalu_pkg::OP_NE:    o_cmp = (i_cur != i_opv);
            default: begin
                o_res = '0;
                o_cmp = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/seqalu_div.sv -----
// Iterative signed 16-bit divider (restoring, one quotient bit per cycle).
// Depends on seqalu_pkg for the data width.
`timescale 1ns / 1ps

module seqalu_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [seqalu_pkg::DATA_W-1:0] i_dividend,
    input  logic signed [seqalu_pkg::DATA_W-1:0] i_divisor,
    output logic                                 o_done,
    output logic [seqalu_pkg::DATA_W-1:0]        o_quot,
    output logic [seqalu_pkg::DATA_W-1:0]        o_rem
);

    localparam int DW = seqalu_pkg::DATA_W;
    localparam int CW = $clog2(DW + 1);
    localparam logic [CW-1:0] STEP_LAST = CW'(DW);

    logic          r_run;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic          r_neg_q;
    logic          r_neg_r;
    logic [DW-1:0] r_q_out;
    logic [DW-1:0] r_r_out;

    logic [DW:0]   w_shift;
    logic          w_ge;
    logic [DW:0]   w_diff;

    // The partial remainder stays below the divisor, so it fits in DW bits.
    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                if (r_cnt == STEP_LAST) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= i_dividend[DW-1] ? DW'(-i_dividend) : i_dividend;
            r_div   <= i_divisor[DW-1] ? DW'(-i_divisor) : i_divisor;
            r_neg_q <= i_dividend[DW-1] ^ i_divisor[DW-1];
            r_neg_r <= i_dividend[DW-1];
        end else if (r_run) begin
            if (r_cnt != STEP_LAST) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
            end else begin
                // Quotient truncates toward zero; remainder takes the dividend's sign.
                r_q_out <= r_neg_q ? DW'(-r_quo) : r_quo;
                r_r_out <= r_neg_r ? DW'(-r_rem) : r_rem;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q_out;
    assign o_rem  = r_r_out;

endmodule

// ----- hw/rtl/seqalu_varfile.sv -----
// Variable file: shared slots and per-track local slots, each with a written mark.
// Depends on seqalu_pkg for the access structs; one access per cycle, read data registered.
`timescale 1ns / 1ps

module seqalu_varfile #(
    parameter int TRACKS      = 16,
    parameter int SHARED_VARS = 32,
    parameter int LOCAL_VARS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  seqalu_pkg::t_vf_acc i_acc,
    output seqalu_pkg::t_vf_rd  o_rd
);

    localparam int DW       = seqalu_pkg::DATA_W;
    localparam int SW       = seqalu_pkg::SLOT_W;
    localparam int TV_DEPTH = TRACKS * LOCAL_VARS;
    localparam int SH_AW    = (SHARED_VARS > 1) ? $clog2(SHARED_VARS) : 1;
    localparam int TV_AW    = (TV_DEPTH > 1) ? $clog2(TV_DEPTH) : 1;

    logic [DW-1:0]          r_sh_mem [SHARED_VARS];
    logic [DW-1:0]          r_tv_mem [TV_DEPTH];
    logic [SHARED_VARS-1:0] r_sh_wr;
    logic [TV_DEPTH-1:0]    r_tv_wr;
    logic [DW-1:0]          r_rd_data;
    logic                   r_rd_wr;

    logic                   w_is_sh;
    logic [SH_AW-1:0]       w_sh_addr;
    logic [TV_AW-1:0]       w_tv_addr;

    assign w_is_sh   = (i_acc.slot < SW'(SHARED_VARS));
    assign w_sh_addr = SH_AW'(i_acc.slot);
    assign w_tv_addr = TV_AW'(int'(i_acc.track) * LOCAL_VARS + int'(i_acc.slot) - SHARED_VARS);

    always_ff @(posedge i_clk) begin
        if (i_acc.we) begin
            if (w_is_sh) begin
                r_sh_mem[w_sh_addr] <= i_acc.wdata;
            end else begin
                r_tv_mem[w_tv_addr] <= i_acc.wdata;
            end
        end
        r_rd_data <= w_is_sh ? r_sh_mem[w_sh_addr] : r_tv_mem[w_tv_addr];
        r_rd_wr   <= w_is_sh ? r_sh_wr[w_sh_addr] : r_tv_wr[w_tv_addr];
    end

    // Written marks double as valid bits: an unwritten slot reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh_wr <= '0;
            r_tv_wr <= '0;
        end else if (i_acc.we) begin
            if (w_is_sh) begin
                r_sh_wr[w_sh_addr] <= 1'b1;
            end else begin
                r_tv_wr[w_tv_addr] <= 1'b1;
            end
        end
    end

    assign o_rd.written = r_rd_wr;
    assign o_rd.data    = r_rd_wr ? r_rd_data : '0;

endmodule
